// ===== hw/rtl/gfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types, command codes and helpers for the GF(2) polynomial ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package gfp_pkg;

    localparam int POLY_WIDTH_DEF = 64;
    localparam int WORD_W         = 64;
    localparam int HIGH_W         = 63;
    localparam int DEG_W          = 8;
    localparam int CHUNK_W        = 16;
    localparam int CHUNKS         = 8;

    localparam logic [2:0] CMD_XOR = 3'd0;
    localparam logic [2:0] CMD_OR  = 3'd1;
    localparam logic [2:0] CMD_AND = 3'd2;
    localparam logic [2:0] CMD_MUL = 3'd3;
    localparam logic [2:0] CMD_MOD = 3'd4;
    localparam logic [2:0] CMD_SHL = 3'd5;
    localparam logic [2:0] CMD_SHR = 3'd6;

    // Per-cycle control for the cell row.
    typedef struct packed {
        logic en;       // advance one step
        logic clr;      // clear all cells
        logic mul;      // 1: multiply step, 0: remainder step
        logic mbit;     // multiplier bit for this step
        logic ser;      // dividend bit fed into cell 0
    } chain_ctrl_t;

    // Position of the highest set bit in a 16-bit chunk.
    function automatic logic [3:0] top_bit16(input logic [CHUNK_W-1:0] v);
        logic [3:0] pos;
        pos = 4'd0;
        for (int i = 0; i < CHUNK_W; i++) begin
            if (v[i]) begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gfp_cell.sv =====
// ----------------------------------------------------------------------------
// gfp_cell
// One coefficient slice: holds one low and one high accumulator bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_cell (
    input  wire logic               aclk,
    input  wire gfp_pkg::chain_ctrl_t ctrl,
    input  wire logic               lo_in,
    input  wire logic               hi_in,
    input  wire logic               a_bit,
    input  wire logic               b_bit,
    input  wire logic               red,
    output logic                    lo_out,
    output logic                    hi_out
);
    import gfp_pkg::*;

    logic lo_reg, lo_next;
    logic hi_reg, hi_next;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.clr) begin
            lo_next = 1'b0;
            hi_next = 1'b0;
        end else if (ctrl.en) begin
            // shift in from the neighbor, add partial product or divisor
            lo_next = lo_in ^ (ctrl.mul ? (ctrl.mbit & a_bit) : (red & b_bit));
            hi_next = ctrl.mul ? hi_in : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo_out = lo_reg;
    assign hi_out = hi_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gfp_chain.sv =====
// ----------------------------------------------------------------------------
// gfp_chain
// Row of coefficient cells for bit-serial multiply and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_chain #(
    parameter int W = gfp_pkg::POLY_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire gfp_pkg::chain_ctrl_t ctrl,
    input  wire logic [W-1:0]         a_vec,
    input  wire logic [W-1:0]         b_vec,
    input  wire logic [$clog2(W)-1:0] db,
    output logic [W-1:0]              lo_vec,
    output logic [W-1:0]              hi_vec
);
    import gfp_pkg::*;

    logic [W-1:0] shifted;
    logic         red;

    // shifted remainder before reduction; reduce when its divisor-degree bit is set
    assign shifted = {lo_vec[W-2:0], ctrl.ser};
    assign red     = shifted[db];

    for (genvar i = 0; i < W; i++) begin : g_cell
        gfp_cell u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .lo_in  (shifted[i]),
            .hi_in  ((i == 0) ? lo_vec[W-1] : hi_vec[(i == 0) ? 0 : i-1]),
            .a_bit  (a_vec[i]),
            .b_bit  (b_vec[i]),
            .red    (red),
            .lo_out (lo_vec[i]),
            .hi_out (hi_vec[i])
        );
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gfp_degree.sv =====
// ----------------------------------------------------------------------------
// gfp_degree
// Degree scan of a 128-bit result, one 16-bit chunk per cycle from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_degree (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      start,
    input  wire logic [gfp_pkg::CHUNKS*gfp_pkg::CHUNK_W-1:0] vec,
    output logic                                           done,
    output logic signed [gfp_pkg::DEG_W-1:0]               degree
);
    import gfp_pkg::*;

    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [6:0]         deg_reg, deg_next;
    logic [CHUNK_W-1:0] chunk;

    assign chunk = vec[cnt_reg*CHUNK_W +: CHUNK_W];

    always_comb begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        found_next = found_reg;
        deg_next   = deg_reg;
        if (start) begin
            cnt_next   = 3'(CHUNKS - 1);
            busy_next  = 1'b1;
            done_next  = 1'b0;
            found_next = 1'b0;
        end else if (busy_reg) begin
            if (!found_reg && (chunk != '0)) begin
                found_next = 1'b1;
                deg_next   = {cnt_reg, top_bit16(chunk)};
            end
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
        deg_reg <= deg_next;
    end

    assign done   = done_reg;
    assign degree = found_reg ? signed'({1'b0, deg_reg}) : -8'sd1;

endmodule

`default_nettype wire

// ===== hw/rtl/gf2_polynomial_alu.sv =====
// ----------------------------------------------------------------------------
// gf2_polynomial_alu
// GF(2) polynomial ALU: xor, or, and, carry-less multiply, remainder, shifts.
// ----------------------------------------------------------------------------
// Flow: xor/or/and/shifts compute in ST_EXEC, then run the degree scan;
//   multiply and remainder step the cell row one coefficient per cycle,
//   then run the degree scan over 16-bit chunks.
// Overlap: a new word is taken only once the last has left for the output; it is taken while the last
//   result still waits in the output register.
// Reset: synchronous, active-low aresetn clears the sequencer and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_polynomial_alu #(
    parameter int POLY_WIDTH = gfp_pkg::POLY_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_cmd,
    input  wire logic [gfp_pkg::WORD_W-1:0]        s_operand_a,
    input  wire logic [gfp_pkg::WORD_W-1:0]        s_operand_b,
    input  wire logic [5:0]                        s_shift_amount,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [gfp_pkg::WORD_W-1:0]             m_result_low,
    output logic [gfp_pkg::HIGH_W-1:0]             m_result_high,
    output logic signed [gfp_pkg::DEG_W-1:0]       m_result_degree,
    output logic                                   m_a_less_than_b,
    output logic                                   m_a_equals_b
);
    import gfp_pkg::*;

    localparam int W     = POLY_WIDTH;
    localparam int IDX_W = $clog2(W);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,   // wait for an input word
        ST_EXEC = 5'b00010,   // clear the row or compute a direct op
        ST_RUN  = 5'b00100,   // step the cell row once per coefficient
        ST_WRAP = 5'b01000,   // collect the row result, start the scan
        ST_SCAN = 5'b10000    // degree scan, then hand off to the output
    } state_t;

    state_t state_reg, state_next;

    // Operand capture (masked to POLY_WIDTH)
    logic [W-1:0]     a_reg, b_reg;
    logic [2:0]       cmd_reg;
    logic [5:0]       sh_reg;
    logic [IDX_W-1:0] db_reg, db_in;
    logic             bzero_reg;
    logic             lt_reg, eq_reg;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] bit_idx;

    // Result staging
    logic [WORD_W-1:0] res_lo_reg;
    logic [HIGH_W-1:0] res_hi_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  out_lo_reg;
    logic [HIGH_W-1:0]  out_hi_reg;
    logic signed [DEG_W-1:0] out_deg_reg;
    logic               out_lt_reg, out_eq_reg;

    logic [W-1:0]       a_in, b_in;
    logic               accept, load_out;
    chain_ctrl_t        ctrl;
    logic [W-1:0]       lo_vec, hi_vec;
    logic [127:0]       shl_wide, prod_wide;
    logic               deg_done;
    logic signed [DEG_W-1:0] deg_val;

    assign a_in   = s_operand_a[W-1:0];
    assign b_in   = s_operand_b[W-1:0];
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Divisor degree; only meaningful when the divisor is nonzero
    always_comb begin
        db_in = '0;
        for (int i = 0; i < W; i++) begin
            if (b_in[i]) begin
                db_in = IDX_W'(i);
            end
        end
    end

    // Coefficients enter most significant first
    assign bit_idx = IDX_W'(W - 1) - cnt_reg;

    always_comb begin
        ctrl      = '0;
        ctrl.clr  = (state_reg == ST_EXEC);
        ctrl.en   = (state_reg == ST_RUN);
        ctrl.mul  = (cmd_reg == CMD_MUL);
        ctrl.mbit = b_reg[bit_idx];
        ctrl.ser  = (cmd_reg == CMD_MUL) ? 1'b0 : a_reg[bit_idx];
    end

    gfp_chain #(.W(W)) u_chain (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .a_vec  (a_reg),
        .b_vec  (b_reg),
        .db     (db_reg),
        .lo_vec (lo_vec),
        .hi_vec (hi_vec)
    );

    gfp_degree u_degree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_WRAP),
        .vec     ({1'b0, res_hi_reg, res_lo_reg}),
        .done    (deg_done),
        .degree  (deg_val)
    );

    assign shl_wide  = 128'(a_reg) << sh_reg;
    assign prod_wide = 128'({hi_vec, lo_vec});

    // Hand off once the scan is done and the output slot is free
    assign load_out = (state_reg == ST_SCAN) && deg_done && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next = '0;
                if (cmd_reg inside {CMD_MUL, CMD_MOD}) begin
                    state_next = ST_RUN;
                end else begin
                    state_next = ST_WRAP;
                end
            end
            ST_RUN: begin
                if (cnt_reg == IDX_W'(W - 1)) begin
                    state_next = ST_WRAP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WRAP: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload: capture operands, stage results, load the output word
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg     <= a_in;
            b_reg     <= b_in;
            cmd_reg   <= s_cmd;
            sh_reg    <= s_shift_amount;
            db_reg    <= db_in;
            bzero_reg <= (b_in == '0);
            lt_reg    <= (a_in < b_in);
            eq_reg    <= (a_in == b_in);
        end
        if (state_reg == ST_EXEC) begin
            // only a left shift spills into the high word here
            res_hi_reg <= (cmd_reg == CMD_SHL) ? shl_wide[126:64] : '0;
            case (cmd_reg)
                CMD_XOR: res_lo_reg <= WORD_W'(a_reg ^ b_reg);
                CMD_OR:  res_lo_reg <= WORD_W'(a_reg | b_reg);
                CMD_AND: res_lo_reg <= WORD_W'(a_reg & b_reg);
                CMD_SHL: res_lo_reg <= shl_wide[63:0];
                CMD_SHR: res_lo_reg <= WORD_W'(a_reg >> sh_reg);
                default: res_lo_reg <= '0;
            endcase
        end
        if (state_reg == ST_WRAP) begin
            if (cmd_reg == CMD_MUL) begin
                res_lo_reg <= prod_wide[63:0];
                res_hi_reg <= prod_wide[126:64];
            end else if (cmd_reg == CMD_MOD) begin
                // remainder by zero gives back the dividend
                res_lo_reg <= bzero_reg ? WORD_W'(a_reg) : WORD_W'(lo_vec);
                res_hi_reg <= '0;
            end
        end
        if (load_out) begin
            out_lo_reg  <= res_lo_reg;
            out_hi_reg  <= res_hi_reg;
            out_deg_reg <= deg_val;
            out_lt_reg  <= lt_reg;
            out_eq_reg  <= eq_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_low    = out_lo_reg;
    assign m_result_high   = out_hi_reg;
    assign m_result_degree = out_deg_reg;
    assign m_a_less_than_b = out_lt_reg;
    assign m_a_equals_b    = out_eq_reg;

endmodule

`default_nettype wire

// ===== bench/gf2_alu_checker.sv =====
// ----------------------------------------------------------------------------
// gf2_alu_checker
// Watches both channels of the GF(2) polynomial ALU, computes the expected
// result word for every accepted input word, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gf2_alu_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [2:0]                         s_cmd,
    input  logic [gfp_pkg::WORD_W-1:0]         s_operand_a,
    input  logic [gfp_pkg::WORD_W-1:0]         s_operand_b,
    input  logic [5:0]                         s_shift_amount,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [gfp_pkg::WORD_W-1:0]         m_result_low,
    input  logic [gfp_pkg::HIGH_W-1:0]         m_result_high,
    input  logic signed [gfp_pkg::DEG_W-1:0]   m_result_degree,
    input  logic                               m_a_less_than_b,
    input  logic                               m_a_equals_b,
    output int                                 fail_count,
    output int                                 pending_count
);
    import gfp_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]        low;
        logic [HIGH_W-1:0]        high;
        logic signed [DEG_W-1:0]  degree;
        logic                     lt;
        logic                     eq;
    } alu_result_t;

    alu_result_t expected_words[$];

    function automatic int top_degree(input logic [127:0] v);
        int d;
        d = -1;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                d = i;
            end
        end
        return d;
    endfunction

    function automatic alu_result_t compute_result(input logic [2:0] cmd,
                                                   input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic [5:0] sh);
        alu_result_t r;
        logic [127:0] wide;
        logic [63:0] rem;
        int db;
        wide = '0;
        case (cmd)
            CMD_XOR: wide[63:0] = a ^ b;
            CMD_OR:  wide[63:0] = a | b;
            CMD_AND: wide[63:0] = a & b;
            CMD_MUL: begin
                for (int i = 0; i < 64; i++) begin
                    if (b[i]) begin
                        wide = wide ^ ({64'd0, a} << i);
                    end
                end
            end
            CMD_MOD: begin
                rem = a;
                if (b != 0) begin
                    db = top_degree({64'd0, b});
                    for (int d = 63; d >= db; d--) begin
                        if (rem[d]) begin
                            rem = rem ^ (b << (d - db));
                        end
                    end
                end
                wide[63:0] = rem;
            end
            CMD_SHL: wide = {64'd0, a} << sh;
            CMD_SHR: wide[63:0] = a >> sh;
            default: wide = '0;
        endcase
        wide[127] = 1'b0;
        r.low = wide[63:0];
        r.high = wide[126:64];
        r.degree = DEG_W'(top_degree(wide));
        r.lt = a < b;
        r.eq = a == b;
        return r;
    endfunction

    assign pending_count = expected_words.size();

    always @(posedge aclk) begin
        alu_result_t exp_w;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            // Queue the prediction for every accepted input word.
            if (s_valid && s_ready) begin
                expected_words.insert(expected_words.size(),
                                      compute_result(s_cmd, s_operand_a,
                                                     s_operand_b, s_shift_amount));
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word low=%h", m_result_low);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_result_low !== exp_w.low) begin
                        $error("result_low exp %h got %h", exp_w.low, m_result_low);
                        fail_count <= fail_count + 1;
                    end else if (m_result_high !== exp_w.high) begin
                        $error("result_high exp %h got %h", exp_w.high, m_result_high);
                        fail_count <= fail_count + 1;
                    end else if (m_result_degree !== exp_w.degree) begin
                        $error("result_degree exp %0d got %0d", exp_w.degree,
                               m_result_degree);
                        fail_count <= fail_count + 1;
                    end else if (m_a_less_than_b !== exp_w.lt) begin
                        $error("a_less_than_b exp %b got %b", exp_w.lt, m_a_less_than_b);
                        fail_count <= fail_count + 1;
                    end else if (m_a_equals_b !== exp_w.eq) begin
                        $error("a_equals_b exp %b got %b", exp_w.eq, m_a_equals_b);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_gf2_polynomial_alu.sv =====
// ----------------------------------------------------------------------------
// tb_gf2_polynomial_alu
// Drives directed and random operation words into the GF(2) polynomial ALU
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gf2_polynomial_alu;
    import gfp_pkg::*;

    localparam int RANDOM_WORDS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    // Command code with no operation behind it.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [63:0] s_operand_a;
    logic [63:0] s_operand_b;
    logic [5:0]  s_shift_amount;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_low;
    logic [62:0] m_result_high;
    logic signed [7:0] m_result_degree;
    logic        m_a_less_than_b;
    logic        m_a_equals_b;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    // Set once the stimulus enters its final stretch: no idling from then on.
    logic        calm_phase;
    // Set once the long receiver hold-off is over.
    logic        holdoff_done;

    gf2_polynomial_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .s_shift_amount(s_shift_amount),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_low(m_result_low), .m_result_high(m_result_high),
        .m_result_degree(m_result_degree),
        .m_a_less_than_b(m_a_less_than_b), .m_a_equals_b(m_a_equals_b)
    );

    gf2_alu_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .s_shift_amount(s_shift_amount),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_low(m_result_low), .m_result_high(m_result_high),
        .m_result_degree(m_result_degree),
        .m_a_less_than_b(m_a_less_than_b), .m_a_equals_b(m_a_equals_b),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Random 64-bit polynomial, biased toward sparse, dense and short shapes.
    function automatic logic [63:0] rand_poly();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            1: v = v | {$urandom, $urandom};
            2: v = v >> $urandom_range(0, 63);
            3: v = 64'd1 << $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    // Offer one word and hold it until accepted, after an optional idle burst.
    // Valid stays high between back-to-back words; drop it only to idle.
    task automatic send_word(input logic [2:0] cmd, input logic [63:0] a,
                             input logic [63:0] b, input logic [5:0] sh);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_operand_a    <= a;
        s_operand_b    <= b;
        s_shift_amount <= sh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Receiver: one long hold-off early on, then random stall bursts.
    initial begin
        int burst;
        m_ready      = 1'b0;
        holdoff_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        // Hold off long enough for the block to fill up and stall its input.
        repeat (400) @(posedge aclk);
        holdoff_done = 1'b1;
        forever begin
            if (!calm_phase && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 10);
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                burst = $urandom_range(1, 20);
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_gf2_polynomial_alu NOT OK");
            $finish;
        end
    end

    initial begin
        logic [63:0] a;
        logic [63:0] b;
        logic [2:0] cmd;
        cycle_count    = 0;
        calm_phase     = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_XOR;
        s_operand_a    = '0;
        s_operand_b    = '0;
        s_shift_amount = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every command, and the special cases.
        send_word(CMD_XOR, '1, '0, 6'd0);
        send_word(CMD_OR, '0, '0, 6'd0);
        send_word(CMD_AND, '1, '1, 6'd63);
        send_word(CMD_MUL, '1, '1, 6'd0);
        send_word(CMD_MUL, '0, '1, 6'd0);           // zero operand
        send_word(CMD_MUL, '1, '0, 6'd0);
        send_word(CMD_MUL, 64'd1, 64'h8000_0000_0000_0000, 6'd0);
        send_word(CMD_MOD, 64'h1234_5678_9abc_def0, '0, 6'd0);  // divide by zero
        send_word(CMD_MOD, '0, 64'h11b, 6'd0);      // zero dividend
        send_word(CMD_MOD, '1, 64'd1, 6'd0);
        send_word(CMD_MOD, '1, 64'h8000_0000_0000_001b, 6'd0);
        send_word(CMD_MOD, 64'h5, 64'h11b, 6'd0);   // dividend below divisor
        send_word(CMD_SHL, '1, '0, 6'd63);
        send_word(CMD_SHL, '1, '1, 6'd0);
        send_word(CMD_SHR, '1, 64'd5, 6'd63);       // top bit lands on x^0
        send_word(CMD_SHR, 64'h8000_0000_0000_0001, '0, 6'd0);
        send_word(CMD_UNUSED, '1, 64'd3, 6'd5);
        send_word(CMD_UNUSED, 64'd3, 64'd3, 6'd0);
        send_word(CMD_XOR, 64'd7, 64'd7, 6'd0);     // equal operands

        // Random: the last tenth of the words runs with no idling, if the hold-off is over by then.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS * 9 / 10 && holdoff_done) begin
                calm_phase = 1'b1;
            end
            cmd = 3'($urandom_range(0, 7));
            a = rand_poly();
            b = ($urandom_range(0, 9) == 0) ? a : rand_poly();
            send_word(cmd, a, b, 6'($urandom_range(0, 63)));
        end
        s_valid <= 1'b0;
        calm_phase = 1'b1;

        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_gf2_polynomial_alu OK");
        end else begin
            $display("tb_gf2_polynomial_alu NOT OK");
        end
        $finish;
    end

endmodule
